/* rtl/swr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swr_pkg
// Shared types and constants of the sliding window receiver: beat layouts,
// configuration registers, result kinds and control states.
// ----------------------------------------------------------------------------
package swr_pkg;

  typedef struct packed {
    logic        corrupted;
    logic        is_data;
    logic [7:0]  target_id;
    logic [7:0]  sender_id;
    logic [7:0]  seq_no;
    logic [63:0] payload;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  peer_id;
    logic [7:0]  number;
    logic [63:0] payload_out;
    logic        last;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] receiver_id;
    logic [4:0] sender_count;
  } cfg_t;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  localparam logic REG_RECEIVER_ID  = 1'b0;
  localparam logic REG_SENDER_COUNT = 1'b1;

  localparam logic [7:0] RECEIVER_ID_RESET  = 8'd0;
  localparam logic [4:0] SENDER_COUNT_RESET = 5'd1;
  localparam logic [7:0] NEXT_EXPECTED_RESET = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_READ,
    ST_DELIVER,
    ST_ACK
  } state_e;

endpackage
`default_nettype wire

/* rtl/swr_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swr_cfg
// APB register file holding the receiver identifier and the sender count.
// ----------------------------------------------------------------------------
module swr_cfg (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  output swr_pkg::cfg_t     cfg_o
);

  swr_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic          reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        swr_pkg::REG_RECEIVER_ID:  cfg_d.receiver_id  = pwdata[7:0];
        swr_pkg::REG_SENDER_COUNT: cfg_d.sender_count = pwdata[4:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      swr_pkg::REG_RECEIVER_ID:  prdata = {24'd0, cfg_q.receiver_id};
      swr_pkg::REG_SENDER_COUNT: prdata = {27'd0, cfg_q.sender_count};
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.receiver_id  <= swr_pkg::RECEIVER_ID_RESET;
      cfg_q.sender_count <= swr_pkg::SENDER_COUNT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* rtl/swr_state_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swr_state_mem
// Per-sender window state memory: one synchronous read port, one write port,
// and a valid bit per entry so an unwritten entry reads as its reset value.
// ----------------------------------------------------------------------------
module swr_state_mem #(
  parameter int Depth = 16,
  parameter int Width = 16,
  parameter int AddrW = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o,
  output logic                  rvalid_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Depth-1:0] valid_q;
  logic [Width-1:0] rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

endmodule
`default_nettype wire

/* rtl/swr_slot_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swr_slot_mem
// Buffered payload words, one per window slot per sender. Synchronous,
// registered read; the read data holds until the next read.
// ----------------------------------------------------------------------------
module swr_slot_mem #(
  parameter int Depth = 128,
  parameter int AddrW = 7
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [63:0]      wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [63:0]      rdata_o
);

  logic [63:0] mem_q [Depth];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/sliding_window_receiver.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_receiver
// Selective-repeat receiver with one receive window per sender.
// ----------------------------------------------------------------------------
// One frame is handled at a time. A dropped frame leaves the receiver idle;
// any other frame goes on to a state lookup. A buffered out-of-order frame
// or an out-of-window frame then returns to idle, a duplicate goes on to an
// acknowledgement, and an in-order frame goes through a slot read and a
// delivery for itself and for each buffered frame that it releases, then to
// an acknowledgement; delivery and acknowledgement wait while the output is
// stalled. A new frame is accepted while the last result still waits in the
// output register. Window state comes up at its reset value at once; the
// slot memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module sliding_window_receiver #(
  parameter int MAX_SENDERS = 16,
  parameter int WINDOW_SIZE = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire swr_pkg::in_beat_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output swr_pkg::out_beat_t      out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int SW   = (MAX_SENDERS > 1) ? $clog2(MAX_SENDERS) : 1;
  localparam int WW   = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int WLOG = $clog2(WINDOW_SIZE);
  localparam int PD   = MAX_SENDERS * WINDOW_SIZE;
  localparam int PAW  = (PD > 1) ? $clog2(PD) : 1;
  localparam int SEW  = 8 + WINDOW_SIZE;

  swr_pkg::cfg_t      cfg;
  swr_pkg::state_e    state_q, state_d;
  swr_pkg::in_beat_t  in_q;
  swr_pkg::out_beat_t out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]             nfe_q, nfe_d;
  logic [WINDOW_SIZE-1:0] marks_q, marks_d;

  logic                   frame_ok;
  logic                   in_accept;
  logic [SW-1:0]          sidx;
  logic [WW-1:0]          slot_in, slot_cur, slot_next;
  logic [7:0]             nfe_inc;
  logic [7:0]             cur_nfe;
  logic [WINDOW_SIZE-1:0] cur_marks, marks_new, marks_after;
  logic [7:0]             offset;
  logic                   in_win, dup, in_order;
  logic                   out_free, out_load;

  logic                   st_re, st_we, st_rvalid;
  logic [SEW-1:0]         st_rdata, st_wdata;
  logic [SW-1:0]          st_raddr;
  logic                   pay_we, pay_re;
  logic [PAW-1:0]         pay_waddr, pay_raddr;
  logic [63:0]            pay_rdata;

  swr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  swr_state_mem #(
    .Depth (MAX_SENDERS),
    .Width (SEW),
    .AddrW (SW)
  ) u_state_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (st_we),
    .waddr_i  (sidx),
    .wdata_i  (st_wdata),
    .re_i     (st_re),
    .raddr_i  (st_raddr),
    .rdata_o  (st_rdata),
    .rvalid_o (st_rvalid)
  );

  swr_slot_mem #(
    .Depth (PD),
    .AddrW (PAW)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (pay_waddr),
    .wdata_i (in_q.payload),
    .re_i    (pay_re),
    .raddr_i (pay_raddr),
    .rdata_o (pay_rdata)
  );

  // Frame filter on the incoming beat
  assign frame_ok = !in_data_i.corrupted && in_data_i.is_data &&
                    (in_data_i.target_id == cfg.receiver_id) &&
                    ({1'b0, in_data_i.sender_id} < {4'd0, cfg.sender_count}) &&
                    ({1'b0, in_data_i.sender_id} < 9'(MAX_SENDERS));

  assign in_stall_o = (state_q != swr_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign st_re      = in_accept && frame_ok;
  assign st_raddr   = in_data_i.sender_id[SW-1:0];

  assign sidx      = in_q.sender_id[SW-1:0];
  assign slot_in   = WW'(in_q.seq_no % WINDOW_SIZE);
  assign slot_cur  = WW'(nfe_q % WINDOW_SIZE);
  assign nfe_inc   = nfe_q + 8'd1;
  assign slot_next = WW'(nfe_inc % WINDOW_SIZE);

  assign cur_nfe   = st_rvalid ? st_rdata[SEW-1 -: 8] : swr_pkg::NEXT_EXPECTED_RESET;
  assign cur_marks = st_rvalid ? st_rdata[WINDOW_SIZE-1:0] : '0;
  assign offset    = in_q.seq_no - cur_nfe;
  assign in_win    = ({1'b0, offset} < 9'(WINDOW_SIZE));
  assign dup       = cur_marks[slot_in];
  assign in_order  = (in_q.seq_no == cur_nfe);
  assign marks_new   = cur_marks | (WINDOW_SIZE'(1) << slot_in);
  assign marks_after = marks_q & ~(WINDOW_SIZE'(1) << slot_cur);

  assign pay_waddr = (PAW'(sidx) << WLOG) | PAW'(slot_in);
  assign pay_raddr = (PAW'(sidx) << WLOG) | PAW'(slot_cur);

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      swr_pkg::ST_IDLE: begin
        if (in_valid_i && frame_ok) begin
          state_d = swr_pkg::ST_LOOKUP;
        end
      end
      swr_pkg::ST_LOOKUP: begin
        if (!in_win) begin
          state_d = swr_pkg::ST_IDLE;
        end else if (dup) begin
          state_d = swr_pkg::ST_ACK;
        end else if (in_order) begin
          state_d = swr_pkg::ST_READ;
        end else begin
          state_d = swr_pkg::ST_IDLE;
        end
      end
      swr_pkg::ST_READ: state_d = swr_pkg::ST_DELIVER;
      swr_pkg::ST_DELIVER: begin
        if (out_free) begin
          state_d = marks_after[slot_next] ? swr_pkg::ST_READ : swr_pkg::ST_ACK;
        end
      end
      swr_pkg::ST_ACK: begin
        if (out_free) begin
          state_d = swr_pkg::ST_IDLE;
        end
      end
      default: state_d = swr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    nfe_d    = nfe_q;
    marks_d  = marks_q;
    st_we    = 1'b0;
    st_wdata = {nfe_q, marks_q};
    pay_we   = 1'b0;
    pay_re   = 1'b0;
    out_load = 1'b0;
    out_d    = out_q;
    case (state_q)
      swr_pkg::ST_LOOKUP: begin
        nfe_d = cur_nfe;
        if (in_win && dup) begin
          marks_d = cur_marks;
        end else if (in_win) begin
          marks_d  = marks_new;
          pay_we   = 1'b1;
          st_we    = !in_order;
          st_wdata = {cur_nfe, marks_new};
        end
      end
      swr_pkg::ST_READ: pay_re = 1'b1;
      swr_pkg::ST_DELIVER: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.kind        = swr_pkg::KIND_DELIVER;
          out_d.peer_id     = in_q.sender_id;
          out_d.number      = nfe_q;
          out_d.payload_out = pay_rdata;
          out_d.last        = 1'b0;
          marks_d           = marks_after;
          nfe_d             = nfe_inc;
        end
      end
      swr_pkg::ST_ACK: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.kind        = swr_pkg::KIND_ACK;
          out_d.peer_id     = in_q.sender_id;
          out_d.number      = nfe_q - 8'd1;
          out_d.payload_out = 64'd0;
          out_d.last        = 1'b1;
          st_we             = 1'b1;
        end
      end
      default: begin
        nfe_d = nfe_q;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
    nfe_q   <= nfe_d;
    marks_q <= marks_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_read_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swr_pkg::ST_READ) |-> marks_q[slot_cur])
    else $error("slot read without a buffered frame");

  a_ack_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swr_pkg::ST_ACK && out_free) |=> (state_q == swr_pkg::ST_IDLE))
    else $error("acknowledgement did not end the frame");

  a_deliver_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == swr_pkg::KIND_DELIVER) |-> !out_data_o.last)
    else $error("delivered frame flagged as last result");

  a_no_mem_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pay_we |-> (!pay_re && $past(st_re)))
    else $error("slot write outside the lookup cycle");

endmodule
`default_nettype wire
